// ===== hdl/etrt_pkg.sv =====
// Shared types and constants for the edge trigger router table.
// Used by the controller, the top level and the port checker; no dependencies.
package etrt_pkg;

    localparam int CAPACITY     = 32;
    localparam int DEVICE_COUNT = 8;

    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DEV_IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

    localparam logic [5:0] DEV_LIMIT = 6'(DEVICE_COUNT);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_RESET  = 3'd3;
    localparam logic [2:0] REQ_EVENT  = 3'd4;

    localparam logic [3:0] STS_INSERTED  = 4'd0;
    localparam logic [3:0] STS_PRESENT   = 4'd1;
    localparam logic [3:0] STS_FULL      = 4'd2;
    localparam logic [3:0] STS_INVALID   = 4'd3;
    localparam logic [3:0] STS_REMOVED   = 4'd4;
    localparam logic [3:0] STS_NOT_FOUND = 4'd5;
    localparam logic [3:0] STS_CLEARED   = 4'd6;
    localparam logic [3:0] STS_RESET     = 4'd7;
    localparam logic [3:0] STS_EVENT     = 4'd8;

    localparam int RULE_W = 13;

    typedef struct packed {
        logic [4:0] device;
        logic [3:0] input_pin;
        logic [3:0] output_pin;
    } rule_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  device;
        logic [3:0]  input_pin;
        logic [3:0]  output_pin;
        logic [15:0] pin_state;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] toggle_mask;
        logic [5:0]  rule_count;
    } result_t;

endpackage

// ===== hdl/edge_trigger_router_table.sv =====
// Top level of the edge trigger router table: controller, rule RAM, output register.
// Depends on etrt_pkg, etrt_ctrl and etrt_rule_ram.
//
//   channel | prefix | handshake       | payload
//   request | s_     | s_valid/s_ready | req_type device input_pin output_pin pin_state
//   result  | m_     | m_valid/m_ready | status toggle_mask rule_count
//
// Clear, history reset, invalid and priming words skip the table walk; insert and event
// walk every held rule, insert ending early when a duplicate is found; remove walks until
// it finds the match, then shifts the later entries down. The walk is set by the single registered
// read port of the rule RAM, one entry per cycle.
// aresetn is synchronous, active low; it empties the table and the edge history.
// A finished result waits in the output register; the next word is accepted meanwhile.
module edge_trigger_router_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [4:0]  s_device,
    input  logic [3:0]  s_input_pin,
    input  logic [3:0]  s_output_pin,
    input  logic [15:0] s_pin_state,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [15:0] m_toggle_mask,
    output logic [5:0]  m_rule_count
);

    etrt_pkg::req_t                 req;
    etrt_pkg::result_t              result;
    logic                           done;
    logic                           out_free;
    logic                           ram_we;
    logic [etrt_pkg::IDX_W-1:0]     ram_waddr;
    logic [etrt_pkg::IDX_W-1:0]     ram_raddr;
    etrt_pkg::rule_t                ram_wdata;
    etrt_pkg::rule_t                ram_rdata;
    logic                           m_valid_reg;
    etrt_pkg::result_t              m_result_reg;

    assign req = '{req_type: s_req_type, device: s_device, input_pin: s_input_pin,
                   output_pin: s_output_pin, pin_state: s_pin_state};

    assign out_free = !m_valid_reg || m_ready;

    etrt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .req_in    (req),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    etrt_rule_ram #(
        .DATA_W (etrt_pkg::RULE_W),
        .ADDR_W (etrt_pkg::IDX_W),
        .DEPTH  (etrt_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_result_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_result_reg.status;
    assign m_toggle_mask = m_result_reg.toggle_mask;
    assign m_rule_count  = m_result_reg.rule_count;

endmodule

// ===== hdl/etrt_rule_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the rule entries; no dependencies.
module etrt_rule_ram #(
    parameter int DATA_W = 13,
    parameter int ADDR_W = 5,
    parameter int DEPTH  = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/etrt_ctrl.sv =====
// Request sequencer: walks the rule RAM through its one read port with a compare unit
// shared by insert and remove, shifts entries on remove, and keeps the edge history.
// Depends on etrt_pkg.
module etrt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  etrt_pkg::req_t        req_in,
    input  logic                  out_free,
    output logic                  done,
    output etrt_pkg::result_t     result,
    output logic                  ram_we,
    output logic [etrt_pkg::IDX_W-1:0] ram_waddr,
    output etrt_pkg::rule_t       ram_wdata,
    output logic [etrt_pkg::IDX_W-1:0] ram_raddr,
    input  etrt_pkg::rule_t       ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [2:0]                      op_reg, op_next;
    etrt_pkg::rule_t                 rule_reg, rule_next;
    logic [15:0]                     rising_reg, rising_next;
    logic [15:0]                     mask_reg, mask_next;
    logic [3:0]                      status_reg, status_next;
    logic [etrt_pkg::CNT_W-1:0]      held_reg, held_next;
    logic [etrt_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [etrt_pkg::IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [15:0]                     last_reg [etrt_pkg::DEVICE_COUNT];
    logic [15:0]                     last_next [etrt_pkg::DEVICE_COUNT];
    logic [etrt_pkg::DEVICE_COUNT-1:0] primed_reg, primed_next;

    logic                            issue;
    logic                            match_rule;
    logic                            drained;
    logic                            dev_ok;
    logic [etrt_pkg::DEV_IDX_W-1:0]  dev_idx;

    assign issue      = (idx_reg < held_reg);
    assign match_rule = rd_vld_reg && (ram_rdata == rule_reg);
    assign drained    = !issue && !rd_vld_reg;
    assign dev_ok     = ({1'b0, req_in.device} < etrt_pkg::DEV_LIMIT);
    assign dev_idx    = req_in.device[etrt_pkg::DEV_IDX_W-1:0];
    assign ram_raddr  = idx_reg[etrt_pkg::IDX_W-1:0];

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        rule_next   = rule_reg;
        rising_next = rising_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        held_next   = held_reg;
        idx_next    = idx_reg;
        rd_vld_next = rd_vld_reg;
        rd_idx_next = rd_idx_reg;
        last_next   = last_reg;
        primed_next = primed_reg;
        s_ready     = 1'b0;
        done        = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = held_reg[etrt_pkg::IDX_W-1:0];
        ram_wdata   = rule_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = req_in.req_type;
                    rule_next   = '{device: req_in.device, input_pin: req_in.input_pin,
                                    output_pin: req_in.output_pin};
                    mask_next   = '0;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    case (req_in.req_type)
                        etrt_pkg::REQ_INSERT: begin
                            if (dev_ok) begin
                                state_next = S_SCAN;
                            end else begin
                                status_next = etrt_pkg::STS_INVALID;
                                state_next  = S_DONE;
                            end
                        end
                        etrt_pkg::REQ_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        etrt_pkg::REQ_CLEAR: begin
                            held_next   = '0;
                            status_next = etrt_pkg::STS_CLEARED;
                            state_next  = S_DONE;
                        end
                        etrt_pkg::REQ_RESET: begin
                            for (int d = 0; d < etrt_pkg::DEVICE_COUNT; d++) begin
                                last_next[d] = '0;
                            end
                            primed_next = '0;
                            status_next = etrt_pkg::STS_RESET;
                            state_next  = S_DONE;
                        end
                        etrt_pkg::REQ_EVENT: begin
                            status_next = etrt_pkg::STS_EVENT;
                            state_next  = S_DONE;
                            if (dev_ok) begin
                                last_next[dev_idx] = req_in.pin_state;
                                if (!primed_reg[dev_idx]) begin
                                    primed_next[dev_idx] = 1'b1;
                                end else begin
                                    rising_next = req_in.pin_state & ~last_reg[dev_idx];
                                    state_next  = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            status_next = etrt_pkg::STS_INVALID;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_vld_next = issue;
                rd_idx_next = idx_reg[etrt_pkg::IDX_W-1:0];
                if (issue) begin
                    idx_next = idx_reg + etrt_pkg::CNT_W'(1);
                end
                case (op_reg)
                    etrt_pkg::REQ_INSERT: begin
                        if (match_rule) begin
                            status_next = etrt_pkg::STS_PRESENT;
                            state_next  = S_DONE;
                        end else if (drained) begin
                            if (held_reg >= etrt_pkg::CNT_W'(etrt_pkg::CAPACITY)) begin
                                status_next = etrt_pkg::STS_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                held_next   = held_reg + etrt_pkg::CNT_W'(1);
                                status_next = etrt_pkg::STS_INSERTED;
                            end
                            state_next = S_DONE;
                        end
                    end
                    etrt_pkg::REQ_REMOVE: begin
                        if (match_rule) begin
                            idx_next    = etrt_pkg::CNT_W'(rd_idx_reg) + etrt_pkg::CNT_W'(1);
                            rd_vld_next = 1'b0;
                            state_next  = S_SHIFT;
                        end else if (drained) begin
                            status_next = etrt_pkg::STS_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                    end
                    default: begin
                        if (rd_vld_reg && (ram_rdata.device == rule_reg.device) &&
                            rising_reg[ram_rdata.input_pin]) begin
                            mask_next = mask_reg | (16'd1 << ram_rdata.output_pin);
                        end
                        if (drained) begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                rd_vld_next = issue;
                rd_idx_next = idx_reg[etrt_pkg::IDX_W-1:0];
                if (issue) begin
                    idx_next = idx_reg + etrt_pkg::CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - etrt_pkg::IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (drained) begin
                    held_next   = held_reg - etrt_pkg::CNT_W'(1);
                    status_next = etrt_pkg::STS_REMOVED;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            held_reg   <= '0;
            rd_vld_reg <= 1'b0;
            primed_reg <= '0;
            for (int d = 0; d < etrt_pkg::DEVICE_COUNT; d++) begin
                last_reg[d] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            rd_vld_reg <= rd_vld_next;
            primed_reg <= primed_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        rule_reg   <= rule_next;
        rising_reg <= rising_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign result = '{status: status_reg, toggle_mask: mask_reg, rule_count: 6'(held_reg)};

endmodule

// ===== hdl/etrt_checker.sv =====
// Port-level checks for the edge trigger router table, bound to the top level.
// Depends on etrt_pkg and edge_trigger_router_table.
module etrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_req_type,
    input logic [4:0]  s_device,
    input logic [3:0]  s_input_pin,
    input logic [3:0]  s_output_pin,
    input logic [15:0] s_pin_state,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic [15:0] m_toggle_mask,
    input logic [5:0]  m_rule_count
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_toggle_mask)
            && $stable(m_rule_count))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a word is in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {3'b000, m_rule_count} <= 9'(etrt_pkg::CAPACITY))
        else $error("rule count beyond capacity");

    a_mask_only_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != etrt_pkg::STS_EVENT) |-> m_toggle_mask == 16'd0)
        else $error("toggle mask set on a non-event word");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == etrt_pkg::STS_INSERTED) |-> m_rule_count != 6'd0)
        else $error("insert reported with an empty table");

endmodule

bind edge_trigger_router_table etrt_checker u_etrt_checker (.*);

// ===== tb/edge_trigger_router_table_test.sv =====
// Self-checking testbench for edge_trigger_router_table: directed table, then random traffic.
// Expected words come from typed rows, else a predictor of the rule table and edge history.
// Depends on etrt_pkg and the RTL of edge_trigger_router_table.
`timescale 1ns / 100ps

module edge_trigger_router_table_test;

    localparam int RANDOM_WORDS = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int CALM_FIRST   = 240;
    localparam int CALM_LAST    = 360;

    typedef struct {
        etrt_pkg::req_t    word;
        bit                typed;
        etrt_pkg::result_t want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_req_type;
    logic [4:0]  s_device;
    logic [3:0]  s_input_pin;
    logic [3:0]  s_output_pin;
    logic [15:0] s_pin_state;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_status;
    logic [15:0] m_toggle_mask;
    logic [5:0]  m_rule_count;

    etrt_pkg::rule_t                   rule_list [etrt_pkg::CAPACITY];
    int                                rule_total;
    logic [15:0]                       level_history [etrt_pkg::DEVICE_COUNT];
    logic [etrt_pkg::DEVICE_COUNT-1:0] primed_mask;

    etrt_pkg::result_t expected_results [$];
    script_row_t       script [$];
    etrt_pkg::result_t head;
    int                fail_count;
    int                words_sent;
    int                results_seen;
    int                toggling_events;
    int                status_tally [16];
    bit                calm;

    edge_trigger_router_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_device      (s_device),
        .s_input_pin   (s_input_pin),
        .s_output_pin  (s_output_pin),
        .s_pin_state   (s_pin_state),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_toggle_mask (m_toggle_mask),
        .m_rule_count  (m_rule_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic etrt_pkg::req_t pack_word(input int rt, input int dev, input int pin_in,
                                                 input int pin_out, input int levels);
        etrt_pkg::req_t w;
        w.req_type   = 3'(rt);
        w.device     = 5'(dev);
        w.input_pin  = 4'(pin_in);
        w.output_pin = 4'(pin_out);
        w.pin_state  = 16'(levels);
        return w;
    endfunction

    function automatic script_row_t row(input int rt, input int dev, input int pin_in,
                                        input int pin_out, input int levels, input bit typed,
                                        input int st, input int mask, input int cnt);
        script_row_t r;
        r.word             = pack_word(rt, dev, pin_in, pin_out, levels);
        r.typed            = typed;
        r.want.status      = 4'(st);
        r.want.toggle_mask = 16'(mask);
        r.want.rule_count  = 6'(cnt);
        return r;
    endfunction

    function automatic logic [15:0] random_levels();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) return 16'h0000;
        if (p < 20) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic etrt_pkg::req_t fresh_rule_word();
        return pack_word(etrt_pkg::REQ_INSERT, $urandom_range(0, etrt_pkg::DEVICE_COUNT - 1),
                         $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    endfunction

    function automatic etrt_pkg::req_t event_word(input int dev);
        return pack_word(etrt_pkg::REQ_EVENT, dev, $urandom_range(0, 15),
                         $urandom_range(0, 15), random_levels());
    endfunction

    function automatic etrt_pkg::req_t noise_word();
        return pack_word($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom);
    endfunction

    function automatic etrt_pkg::req_t held_word(input int rt);
        etrt_pkg::rule_t pick;
        if (rule_total == 0) begin
            return pack_word(rt, $urandom_range(0, etrt_pkg::DEVICE_COUNT - 1),
                             $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end
        pick = rule_list[$urandom_range(0, rule_total - 1)];
        return pack_word(rt, pick.device, pick.input_pin, pick.output_pin, $urandom);
    endfunction

    task automatic route_request(input etrt_pkg::req_t w, output etrt_pkg::result_t r);
        etrt_pkg::rule_t                probe;
        int                             hit;
        logic [15:0]                    rising;
        logic [etrt_pkg::DEV_IDX_W-1:0] dev_idx;
        probe.device     = w.device;
        probe.input_pin  = w.input_pin;
        probe.output_pin = w.output_pin;
        dev_idx          = w.device[etrt_pkg::DEV_IDX_W-1:0];
        hit = -1;
        for (int i = rule_total - 1; i >= 0; i--) begin
            if (rule_list[i] == probe) hit = i;
        end
        r.toggle_mask = '0;
        case (w.req_type)
            etrt_pkg::REQ_INSERT: begin
                if (w.device >= etrt_pkg::DEVICE_COUNT) begin
                    r.status = etrt_pkg::STS_INVALID;
                end else if (hit >= 0) begin
                    r.status = etrt_pkg::STS_PRESENT;
                end else if (rule_total >= etrt_pkg::CAPACITY) begin
                    r.status = etrt_pkg::STS_FULL;
                end else begin
                    rule_list[rule_total] = probe;
                    rule_total++;
                    r.status = etrt_pkg::STS_INSERTED;
                end
            end
            etrt_pkg::REQ_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i < rule_total - 1; i++) rule_list[i] = rule_list[i + 1];
                    rule_total--;
                    r.status = etrt_pkg::STS_REMOVED;
                end else begin
                    r.status = etrt_pkg::STS_NOT_FOUND;
                end
            end
            etrt_pkg::REQ_CLEAR: begin
                rule_total = 0;
                r.status   = etrt_pkg::STS_CLEARED;
            end
            etrt_pkg::REQ_RESET: begin
                foreach (level_history[d]) level_history[d] = '0;
                primed_mask = '0;
                r.status    = etrt_pkg::STS_RESET;
            end
            etrt_pkg::REQ_EVENT: begin
                r.status = etrt_pkg::STS_EVENT;
                if (w.device < etrt_pkg::DEVICE_COUNT) begin
                    if (!primed_mask[dev_idx]) begin
                        primed_mask[dev_idx] = 1'b1;
                    end else begin
                        rising = w.pin_state & ~level_history[dev_idx];
                        for (int i = 0; i < rule_total; i++) begin
                            if (rule_list[i].device == w.device && rising[rule_list[i].input_pin])
                                r.toggle_mask[rule_list[i].output_pin] = 1'b1;
                        end
                    end
                    level_history[dev_idx] = w.pin_state;
                end
            end
            default: r.status = etrt_pkg::STS_INVALID;
        endcase
        r.rule_count = 6'(rule_total);
        status_tally[r.status]++;
        if (r.toggle_mask != '0) toggling_events++;
    endtask

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    task automatic send_word(input etrt_pkg::req_t w, input bit typed,
                             input etrt_pkg::result_t want);
        etrt_pkg::result_t predicted;
        while (!calm && $urandom_range(0, 99) < 36) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_req_type   = w.req_type;
        s_device     = w.device;
        s_input_pin  = w.input_pin;
        s_output_pin = w.output_pin;
        s_pin_state  = w.pin_state;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        route_request(w, predicted);
        expected_results.push_back(typed ? want : predicted);
        words_sent++;
        calm = (words_sent >= CALM_FIRST && words_sent < CALM_LAST);
        @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = calm || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                log_failure($sformatf(
                    "result %0d with nothing pending: status %0d mask %h count %0d",
                    results_seen, m_status, m_toggle_mask, m_rule_count));
            end else begin
                head = expected_results.pop_front();
                if (m_status !== head.status || m_toggle_mask !== head.toggle_mask ||
                    m_rule_count !== head.rule_count) begin
                    log_failure($sformatf(
                        "result %0d: want status %0d mask %h count %0d, got %0d %h %0d",
                        results_seen, head.status, head.toggle_mask, head.rule_count,
                        m_status, m_toggle_mask, m_rule_count));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("no word moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, expected_results.size());
        $display("edge_trigger_router_table test failed");
        $finish;
    end

    initial begin : stimulus
        etrt_pkg::req_t w;
        int             kind;
        int             p;
        bit             first_fill;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = '0;
        s_device     = '0;
        s_input_pin  = '0;
        s_output_pin = '0;
        s_pin_state  = '0;
        calm         = 1'b0;
        rule_total   = 0;
        primed_mask  = '0;
        foreach (level_history[d]) level_history[d] = '0;
        foreach (status_tally[s]) status_tally[s] = 0;

        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'h0000, 1,
                             etrt_pkg::STS_EVENT,     0, 0));
        script.push_back(row(etrt_pkg::REQ_INSERT,  0,  0,  0, 'h0000, 1,
                             etrt_pkg::STS_INSERTED,  0, 1));
        script.push_back(row(etrt_pkg::REQ_INSERT,  0,  0,  0, 'hFFFF, 1,
                             etrt_pkg::STS_PRESENT,   0, 1));
        script.push_back(row(etrt_pkg::REQ_INSERT,  8,  3,  3, 'h0000, 1,
                             etrt_pkg::STS_INVALID,   0, 1));
        script.push_back(row(etrt_pkg::REQ_INSERT, 31, 15, 15, 'hFFFF, 1,
                             etrt_pkg::STS_INVALID,   0, 1));
        script.push_back(row(etrt_pkg::REQ_INSERT,  7, 15, 15, 'h0000, 1,
                             etrt_pkg::STS_INSERTED,  0, 2));
        script.push_back(row(etrt_pkg::REQ_INSERT,  0, 15, 15, 'h0000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'hFFFF, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   7, 15, 15, 'hFFFF, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   7,  0,  0, 'h0000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   7,  0,  0, 'h8000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,  31, 15, 15, 'hFFFF, 1,
                             etrt_pkg::STS_EVENT,     0, 3));
        script.push_back(row(etrt_pkg::REQ_REMOVE,  5,  3,  2, 'h0000, 1,
                             etrt_pkg::STS_NOT_FOUND, 0, 3));
        script.push_back(row(etrt_pkg::REQ_REMOVE, 31, 15, 15, 'hFFFF, 1,
                             etrt_pkg::STS_NOT_FOUND, 0, 3));
        script.push_back(row(etrt_pkg::REQ_REMOVE,  0,  0,  0, 'h0000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'h0000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_RESET,   0,  0,  0, 'h0000, 1,
                             etrt_pkg::STS_RESET,     0, 2));
        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'hFFFF, 0, 0, 0, 0));
        script.push_back(row(5,                     0,  0,  0, 'h0000, 1,
                             etrt_pkg::STS_INVALID,   0, 2));
        script.push_back(row(6,                    16,  8,  8, 'h5555, 1,
                             etrt_pkg::STS_INVALID,   0, 2));
        script.push_back(row(7,                    31, 15, 15, 'hFFFF, 1,
                             etrt_pkg::STS_INVALID,   0, 2));
        script.push_back(row(etrt_pkg::REQ_CLEAR,   0,  0,  0, 'h0000, 1,
                             etrt_pkg::STS_CLEARED,   0, 0));
        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'h0000, 0, 0, 0, 0));
        script.push_back(row(etrt_pkg::REQ_INSERT,  0, 15, 15, 'h0000, 1,
                             etrt_pkg::STS_INSERTED,  0, 1));
        script.push_back(row(etrt_pkg::REQ_EVENT,   0,  0,  0, 'hFFFF, 0, 0, 0, 0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].want);

        first_fill = 1'b1;
        while (words_sent < script.size() + RANDOM_WORDS) begin
            kind = first_fill ? 6 : $urandom_range(0, 9);
            first_fill = 1'b0;
            if (kind <= 5) begin
                repeat ($urandom_range(20, 40)) begin
                    p = $urandom_range(0, 99);
                    if (p < 35)      w = event_word($urandom_range(0, etrt_pkg::DEVICE_COUNT - 1));
                    else if (p < 60) w = fresh_rule_word();
                    else if (p < 68) w = held_word(etrt_pkg::REQ_INSERT);
                    else if (p < 80) w = held_word(etrt_pkg::REQ_REMOVE);
                    else if (p < 84) w = pack_word(etrt_pkg::REQ_REMOVE, $urandom_range(0, 31),
                                                   $urandom_range(0, 15),
                                                   $urandom_range(0, 15), $urandom);
                    else if (p < 86) w = pack_word(etrt_pkg::REQ_CLEAR, 0, 0, 0, $urandom);
                    else if (p < 88) w = pack_word(etrt_pkg::REQ_RESET, 0, 0, 0, $urandom);
                    else             w = noise_word();
                    send_word(w, 1'b0, '0);
                end
            end else if (kind <= 7) begin
                while (rule_total < etrt_pkg::CAPACITY) send_word(fresh_rule_word(), 1'b0, '0);
                repeat (6) begin
                    w = $urandom_range(0, 1) ? held_word(etrt_pkg::REQ_INSERT)
                                             : fresh_rule_word();
                    send_word(w, 1'b0, '0);
                end
                repeat (10) begin
                    send_word(event_word($urandom_range(0, etrt_pkg::DEVICE_COUNT - 1)),
                              1'b0, '0);
                end
                repeat (4) send_word(held_word(etrt_pkg::REQ_REMOVE), 1'b0, '0);
                if ($urandom_range(0, 1)) begin
                    send_word(pack_word(etrt_pkg::REQ_CLEAR, 0, 0, 0, 0), 1'b0, '0);
                end
            end else if (kind == 8) begin
                w = pack_word($urandom_range(0, 1) ? etrt_pkg::REQ_RESET : etrt_pkg::REQ_CLEAR,
                              $urandom_range(0, 31), 0, 0, $urandom);
                send_word(w, 1'b0, '0);
                repeat (3) begin
                    for (int d = 0; d < etrt_pkg::DEVICE_COUNT; d++) begin
                        send_word(event_word(d), 1'b0, '0);
                    end
                end
            end else begin
                repeat ($urandom_range(8, 12)) send_word(noise_word(), 1'b0, '0);
            end
        end
        s_valid = 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d request words: %0d inserted, %0d duplicate, %0d refused full, %0d removed",
                 words_sent, status_tally[etrt_pkg::STS_INSERTED],
                 status_tally[etrt_pkg::STS_PRESENT], status_tally[etrt_pkg::STS_FULL],
                 status_tally[etrt_pkg::STS_REMOVED]);
        $display("%0d events toggled outputs, %0d invalid words, %0d mismatches",
                 toggling_events, status_tally[etrt_pkg::STS_INVALID], fail_count);
        if (fail_count == 0) begin
            $display("edge_trigger_router_table test passed");
        end else begin
            $display("edge_trigger_router_table test failed");
        end
        $finish;
    end

endmodule
